@@ rtl/pmv_pkg.sv @@
// Shared types and constants for the Poynting magnitude voxelizer.
// No dependencies; every other file refers to this package by scoped name.
package pmv_pkg;

   localparam int MAG_W           = 32;
   localparam int OFFSET_W        = 32;
   localparam int GAIN_W          = 24;
   localparam int VOXEL_W         = 8;
   localparam int PROD_W          = OFFSET_W + GAIN_W;
   localparam int ROUND_SHIFT     = 40;

   localparam int SUM_EXT_W       = 128;
   localparam int FRAC_DROP       = 32;
   localparam int RAD_W           = 64;
   localparam int ROOT_W          = 32;
   localparam int REM_W           = ROOT_W + 4;
   localparam int SQRT_STAGES     = 8;
   localparam int STEPS_PER_STAGE = ROOT_W / SQRT_STAGES;

   localparam int CSR_INDEX_W     = 8;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_VOXEL_OFFSET = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_VOXEL_GAIN   = CSR_INDEX_W'(1);

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(0);
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(13056000);
   localparam logic [VOXEL_W-1:0]  VOXEL_MAX    = '1;
   localparam logic [PROD_W-1:0]   ROUND_HALF   = PROD_W'(1) << (ROUND_SHIFT - 1);

   typedef struct packed {
      logic valid;
      logic advance;
   } pipe_ctrl_type;

endpackage

@@ rtl/poynting_magnitude_voxelizer.sv @@
// Top level of the Poynting magnitude voxelizer: CSRs, stall control, stage chain.
// Depends on pmv_pkg, pmv_cross, pmv_square, pmv_sqrt and pmv_voxel.
//
//   channel  direction  ports                                  beat
//   req      in         req_valid/ready, req_ex..req_hz         one grid cell
//   rsp      out        rsp_valid/ready, magnitude/voxel/clip   one result
//   csr      in         csr_valid/ready, csr_index, csr_data    one register write
//
// One cell per clock while no output beat waits; the chain has two cross-product, three
// square-sum, eight root stages (four root bits each) and three voxel stages.
// Reset is synchronous: valid bits clear, voxel_offset 0, voxel_gain 13056000.
// The whole chain holds while an output beat waits; csr_ready is always high.
module poynting_magnitude_voxelizer #(
   parameter int FIELD_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [FIELD_BITS-1:0]        req_ex,
   input  logic signed [FIELD_BITS-1:0]        req_ey,
   input  logic signed [FIELD_BITS-1:0]        req_ez,
   input  logic signed [FIELD_BITS-1:0]        req_hx,
   input  logic signed [FIELD_BITS-1:0]        req_hy,
   input  logic signed [FIELD_BITS-1:0]        req_hz,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pmv_pkg::MAG_W-1:0]           rsp_magnitude,
   output logic [pmv_pkg::VOXEL_W-1:0]         rsp_voxel,
   output logic                                rsp_clipped,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pmv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pmv_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic                            advance;
   pmv_pkg::pipe_ctrl_type          cross_ctrl;
   pmv_pkg::pipe_ctrl_type          square_ctrl;
   pmv_pkg::pipe_ctrl_type          sqrt_ctrl;
   pmv_pkg::pipe_ctrl_type          voxel_ctrl;
   logic                            cross_valid;
   logic [2*FIELD_BITS-1:0]         comp [3];
   logic                            square_valid;
   logic [pmv_pkg::RAD_W-1:0]       radicand;
   logic                            saturate;
   logic                            sqrt_valid;
   logic [pmv_pkg::MAG_W-1:0]       magnitude;
   logic [pmv_pkg::OFFSET_W-1:0]    voxel_offset_ff;
   logic [pmv_pkg::GAIN_W-1:0]      voxel_gain_ff;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_comb begin
      cross_ctrl.valid    = req_valid;
      cross_ctrl.advance  = advance;
      square_ctrl.valid   = cross_valid;
      square_ctrl.advance = advance;
      sqrt_ctrl.valid     = square_valid;
      sqrt_ctrl.advance   = advance;
      voxel_ctrl.valid    = sqrt_valid;
      voxel_ctrl.advance  = advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voxel_offset_ff <= pmv_pkg::OFFSET_RESET;
         voxel_gain_ff   <= pmv_pkg::GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pmv_pkg::CSR_VOXEL_OFFSET: voxel_offset_ff <= csr_data[pmv_pkg::OFFSET_W-1:0];
            pmv_pkg::CSR_VOXEL_GAIN:   voxel_gain_ff   <= csr_data[pmv_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   pmv_cross #(
      .FIELD_BITS (FIELD_BITS)
   ) u_cross (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cross_ctrl),
      .ex        (req_ex),
      .ey        (req_ey),
      .ez        (req_ez),
      .hx        (req_hx),
      .hy        (req_hy),
      .hz        (req_hz),
      .out_valid (cross_valid),
      .comp      (comp)
   );

   pmv_square #(
      .FIELD_BITS (FIELD_BITS)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (square_ctrl),
      .comp      (comp),
      .out_valid (square_valid),
      .radicand  (radicand),
      .saturate  (saturate)
   );

   pmv_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (sqrt_ctrl),
      .radicand  (radicand),
      .saturate  (saturate),
      .out_valid (sqrt_valid),
      .magnitude (magnitude)
   );

   pmv_voxel u_voxel (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (voxel_ctrl),
      .magnitude     (magnitude),
      .voxel_offset  (voxel_offset_ff),
      .voxel_gain    (voxel_gain_ff),
      .out_valid     (rsp_valid),
      .out_magnitude (rsp_magnitude),
      .out_voxel     (rsp_voxel),
      .out_clipped   (rsp_clipped)
   );

`ifndef SYNTHESIS
   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_voxel == '0 || rsp_voxel == pmv_pkg::VOXEL_MAX)
      else $error("clipped flag set away from a rail");
   a_stall_only_on_blocked_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked output beat");
   a_voxel_needs_magnitude: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_voxel != '0 |-> rsp_magnitude != '0)
      else $error("nonzero voxel from zero magnitude");
`endif

endmodule

@@ rtl/pmv_cross.sv @@
// Cross product stages: six signed products, then absolute differences.
// Depends on pmv_pkg for the pipeline control struct.
module pmv_cross #(
   parameter int FIELD_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pmv_pkg::pipe_ctrl_type        ctrl,
   input  logic signed [FIELD_BITS-1:0]  ex,
   input  logic signed [FIELD_BITS-1:0]  ey,
   input  logic signed [FIELD_BITS-1:0]  ez,
   input  logic signed [FIELD_BITS-1:0]  hx,
   input  logic signed [FIELD_BITS-1:0]  hy,
   input  logic signed [FIELD_BITS-1:0]  hz,
   output logic                          out_valid,
   output logic [2*FIELD_BITS-1:0]       comp [3]
);

   localparam int PW = 2 * FIELD_BITS;

   logic signed [PW-1:0] prod_in [6];
   logic signed [PW-1:0] prod_ff [6];
   logic [PW-1:0]        comp_in [3];
   logic [PW-1:0]        comp_ff [3];
   logic                 vld_ff [2];
   logic [PW:0]          dab;
   logic [PW:0]          dba;

   always_comb begin
      prod_in[0] = ey * hz;
      prod_in[1] = ez * hy;
      prod_in[2] = ez * hx;
      prod_in[3] = ex * hz;
      prod_in[4] = ex * hy;
      prod_in[5] = ey * hx;
      dab = '0;
      dba = '0;
      for (int k = 0; k < 3; k++) begin
         dab = {prod_ff[2*k][PW-1], prod_ff[2*k]} - {prod_ff[2*k+1][PW-1], prod_ff[2*k+1]};
         dba = {prod_ff[2*k+1][PW-1], prod_ff[2*k+1]} - {prod_ff[2*k][PW-1], prod_ff[2*k]};
         comp_in[k] = dab[PW] ? dba[PW-1:0] : dab[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         vld_ff[1] <= 1'b0;
      end else if (ctrl.advance) begin
         vld_ff[0] <= ctrl.valid;
         vld_ff[1] <= vld_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         prod_ff <= prod_in;
         comp_ff <= comp_in;
      end
   end

   assign out_valid = vld_ff[1];
   assign comp      = comp_ff;

endmodule

@@ rtl/pmv_square.sv @@
// Square-sum stages: split partial products, square assembly, sum and radicand.
// Depends on pmv_pkg for widths and the pipeline control struct.
module pmv_square #(
   parameter int FIELD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pmv_pkg::pipe_ctrl_type       ctrl,
   input  logic [2*FIELD_BITS-1:0]      comp [3],
   output logic                         out_valid,
   output logic [pmv_pkg::RAD_W-1:0]    radicand,
   output logic                         saturate
);

   localparam int N    = FIELD_BITS;
   localparam int CW   = 2 * FIELD_BITS;
   localparam int SQ_W = 4 * FIELD_BITS;

   logic [CW-1:0]   hh_ff [3];
   logic [CW-1:0]   hl_ff [3];
   logic [CW-1:0]   ll_ff [3];
   logic [CW-1:0]   hh_in [3];
   logic [CW-1:0]   hl_in [3];
   logic [CW-1:0]   ll_in [3];
   logic [SQ_W-1:0] sq_in [3];
   logic [SQ_W-1:0] sq_ff [3];
   logic [SQ_W-1:0] sum;
   logic [pmv_pkg::SUM_EXT_W-1:0] sum_ext;
   logic [pmv_pkg::RAD_W-1:0]     rad_in;
   logic [pmv_pkg::RAD_W-1:0]     rad_ff;
   logic            sat_in;
   logic            sat_ff;
   logic            vld_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hh_in[k] = comp[k][CW-1:N] * comp[k][CW-1:N];
         hl_in[k] = comp[k][CW-1:N] * comp[k][N-1:0];
         ll_in[k] = comp[k][N-1:0] * comp[k][N-1:0];
         sq_in[k] = (SQ_W'(hh_ff[k]) << CW) + (SQ_W'(hl_ff[k]) << (N + 1))
                  + SQ_W'(ll_ff[k]);
      end
      sum     = sq_ff[0] + sq_ff[1] + sq_ff[2];
      sum_ext = pmv_pkg::SUM_EXT_W'(sum);
      rad_in  = sum_ext[pmv_pkg::FRAC_DROP +: pmv_pkg::RAD_W];
      sat_in  = |sum_ext[pmv_pkg::SUM_EXT_W-1:pmv_pkg::FRAC_DROP+pmv_pkg::RAD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         vld_ff[1] <= 1'b0;
         vld_ff[2] <= 1'b0;
      end else if (ctrl.advance) begin
         vld_ff[0] <= ctrl.valid;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         hh_ff  <= hh_in;
         hl_ff  <= hl_in;
         ll_ff  <= ll_in;
         sq_ff  <= sq_in;
         rad_ff <= rad_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign radicand  = rad_ff;
   assign saturate  = sat_ff;

endmodule

@@ rtl/pmv_sqrt.sv @@
// Pipelined restoring square root: four root bits per stage, saturating output.
// Depends on pmv_pkg for widths, stage count and the pipeline control struct.
module pmv_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  pmv_pkg::pipe_ctrl_type     ctrl,
   input  logic [pmv_pkg::RAD_W-1:0]  radicand,
   input  logic                       saturate,
   output logic                       out_valid,
   output logic [pmv_pkg::MAG_W-1:0]  magnitude
);

   typedef struct packed {
      logic [pmv_pkg::RAD_W-1:0]  rad;
      logic [pmv_pkg::REM_W-1:0]  rem;
      logic [pmv_pkg::ROOT_W-1:0] root;
      logic                       sat;
   } sqrt_state_type;

   localparam int NS = pmv_pkg::SQRT_STAGES;

   sqrt_state_type st_in [NS];
   sqrt_state_type st_ff [NS];
   sqrt_state_type st_first;
   logic           vld_ff [NS];

   function automatic sqrt_state_type sqrt_steps(input sqrt_state_type s);
      sqrt_state_type            t;
      logic [pmv_pkg::REM_W-1:0] trial;
      t = s;
      for (int i = 0; i < pmv_pkg::STEPS_PER_STAGE; i++) begin
         t.rem = {t.rem[pmv_pkg::REM_W-3:0], t.rad[pmv_pkg::RAD_W-1 -: 2]};
         t.rad = {t.rad[pmv_pkg::RAD_W-3:0], 2'b00};
         trial = {(pmv_pkg::REM_W - pmv_pkg::ROOT_W - 2)'(0), t.root, 2'b01};
         if (t.rem >= trial) begin
            t.rem  = t.rem - trial;
            t.root = {t.root[pmv_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            t.root = {t.root[pmv_pkg::ROOT_W-2:0], 1'b0};
         end
      end
      return t;
   endfunction

   always_comb begin
      st_first.rad  = radicand;
      st_first.rem  = '0;
      st_first.root = '0;
      st_first.sat  = saturate;
      st_in[0] = sqrt_steps(st_first);
      for (int i = 1; i < NS; i++) begin
         st_in[i] = sqrt_steps(st_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (ctrl.advance) begin
         vld_ff[0] <= ctrl.valid;
         for (int i = 1; i < NS; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign magnitude = st_ff[NS-1].sat ? '1 : st_ff[NS-1].root;

`ifndef SYNTHESIS
   a_root_msb_clear_early: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> st_ff[0].root[pmv_pkg::ROOT_W-1:pmv_pkg::STEPS_PER_STAGE] == '0)
      else $error("root bits beyond the first stage set after one stage");
   a_valid_shift: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance && vld_ff[0] |=> vld_ff[1])
      else $error("valid lost between root stages");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !ctrl.advance |=> $stable(st_ff[NS-1].root) && $stable(vld_ff[NS-1]))
      else $error("last root stage moved during a stall");
`endif

endmodule

@@ rtl/pmv_voxel.sv @@
// Voxel mapping stages: offset difference, gain product, rounding and clamp.
// Holds the output beat register; depends on pmv_pkg for widths and constants.
module pmv_voxel (
   input  logic                          clock,
   input  logic                          reset,
   input  pmv_pkg::pipe_ctrl_type        ctrl,
   input  logic [pmv_pkg::MAG_W-1:0]     magnitude,
   input  logic [pmv_pkg::OFFSET_W-1:0]  voxel_offset,
   input  logic [pmv_pkg::GAIN_W-1:0]    voxel_gain,
   output logic                          out_valid,
   output logic [pmv_pkg::MAG_W-1:0]     out_magnitude,
   output logic [pmv_pkg::VOXEL_W-1:0]   out_voxel,
   output logic                          out_clipped
);

   localparam int PW = pmv_pkg::PROD_W;
   localparam int RS = pmv_pkg::ROUND_SHIFT;
   localparam int VW = pmv_pkg::VOXEL_W;

   logic [pmv_pkg::MAG_W:0]      diff_up;
   logic [pmv_pkg::MAG_W:0]      diff_dn;
   logic [pmv_pkg::MAG_W-1:0]    dist_in;
   logic [pmv_pkg::MAG_W-1:0]    dist_ff;
   logic                         neg_in;
   logic                         neg_ff [2];
   logic [pmv_pkg::MAG_W-1:0]    mag_ff [3];
   logic [PW-1:0]                prod_in;
   logic [PW-1:0]                prod_ff;
   logic [PW:0]                  rsum;
   logic [VW-1:0]                voxel_in;
   logic [VW-1:0]                voxel_ff;
   logic                         clip_in;
   logic                         clip_ff;
   logic                         vld_ff [3];

   always_comb begin
      diff_up = {1'b0, magnitude} - {1'b0, voxel_offset};
      diff_dn = {1'b0, voxel_offset} - {1'b0, magnitude};
      neg_in  = diff_up[pmv_pkg::MAG_W];
      dist_in = neg_in ? diff_dn[pmv_pkg::MAG_W-1:0] : diff_up[pmv_pkg::MAG_W-1:0];
      prod_in = PW'(dist_ff) * PW'(voxel_gain);
      rsum    = {1'b0, prod_ff} + {1'b0, pmv_pkg::ROUND_HALF};
      if (neg_ff[1]) begin
         voxel_in = '0;
         clip_in  = prod_ff > pmv_pkg::ROUND_HALF;
      end else if (|rsum[PW:RS+VW]) begin
         voxel_in = pmv_pkg::VOXEL_MAX;
         clip_in  = 1'b1;
      end else begin
         voxel_in = rsum[RS+VW-1:RS];
         clip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         vld_ff[1] <= 1'b0;
         vld_ff[2] <= 1'b0;
      end else if (ctrl.advance) begin
         vld_ff[0] <= ctrl.valid;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         dist_ff   <= dist_in;
         neg_ff[0] <= neg_in;
         neg_ff[1] <= neg_ff[0];
         mag_ff[0] <= magnitude;
         mag_ff[1] <= mag_ff[0];
         mag_ff[2] <= mag_ff[1];
         prod_ff   <= prod_in;
         voxel_ff  <= voxel_in;
         clip_ff   <= clip_in;
      end
   end

   assign out_valid     = vld_ff[2];
   assign out_magnitude = mag_ff[2];
   assign out_voxel     = voxel_ff;
   assign out_clipped   = clip_ff;

endmodule
